[hw/rtl/sacl_pkg.sv]
// Shared constants, types and helpers for the set-associative LRU cache unit.
package sacl_pkg;

  localparam int WAYS      = 4;
  localparam int SET_BITS  = 8;
  localparam int ADDR_BITS = 48;

  localparam int NUM_SETS  = 1 << SET_BITS;
  localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W     = ADDR_BITS;

  localparam int OFS_W     = 5;
  localparam int SB_W      = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 5;
  localparam int CNT_W     = 32;
  localparam int OUTC_W    = 2;
  localparam int OWAY_W    = 2;

  localparam logic [OFS_W-1:0] OFS_RESET = OFS_W'(4);
  localparam logic [SB_W-1:0]  SB_RESET  = SB_W'(4);
  localparam logic [SB_W-1:0]  SB_MAX    = SB_W'(SET_BITS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 1'b1;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_FILL  = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd2;

  typedef logic [WAY_W-1:0] way_t;
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [SET_W-1:0] set_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // one set: LRU order (position 0 is LRU), valid bits, tags
  typedef struct packed {
    way_t [WAYS-1:0]  lru;
    logic [WAYS-1:0]  valid;
    tag_t [WAYS-1:0]  tag;
  } row_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic rd_en;   // latch address fields and read the set
    logic upd_en;  // resolve the lookup and write the set back
  } dp_cmd_t;

  function automatic way_t [WAYS-1:0] lru_identity();
    way_t [WAYS-1:0] o;
    for (int i = 0; i < WAYS; i++) begin
      o[i] = WAY_W'(i);
    end
    return o;
  endfunction

  function automatic cnt_t sat_inc(cnt_t c);
    return (c == '1) ? c : c + cnt_t'(1);
  endfunction

endpackage

[hw/rtl/sacl_ctrl.sv]
// Controller: sequences the read and write-back of one set per item.
module sacl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  output sacl_pkg::dp_cmd_t cmd
);
  import sacl_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.upd_en;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.rd_en  = 1'b0;
    cmd.upd_en = 1'b0;
    busy       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        busy       = 1'b1;
        cmd.upd_en = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/sacl_dp.sv]
// Datapath: address split, set memory, tag compare, LRU update and counters.
module sacl_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sacl_pkg::dp_cmd_t                 cmd,
  input  logic [sacl_pkg::ADDR_BITS-1:0]    in_address,
  input  logic                              cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sacl_pkg::CFG_W-1:0]        cfg_data,
  output logic [sacl_pkg::OUTC_W-1:0]       out_outcome,
  output logic [sacl_pkg::OWAY_W-1:0]       out_way,
  output logic [sacl_pkg::CNT_W-1:0]        out_hit_count,
  output logic [sacl_pkg::CNT_W-1:0]        out_miss_count,
  output logic [sacl_pkg::CNT_W-1:0]        out_eviction_count
);
  import sacl_pkg::*;

  // configuration
  logic [OFS_W-1:0] ofs_r;
  logic [SB_W-1:0]  sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r <= OFS_RESET;
      sb_r  <= SB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_BITS: ofs_r <= cfg_data[OFS_W-1:0];
        CFG_SET_BITS:    sb_r  <= cfg_data[SB_W-1:0];
        default: ;
      endcase
    end
  end

  // address split
  logic [ADDR_BITS-1:0] shifted;
  logic [SB_W-1:0]      sb_eff;
  set_t                 set_mask;
  set_t                 set_in;
  tag_t                 tag_in;

  always_comb begin
    sb_eff   = (sb_r > SB_MAX) ? SB_MAX : sb_r;
    shifted  = in_address >> ofs_r;
    set_mask = ~(set_t'('1) << sb_eff);
    set_in   = shifted[SET_W-1:0] & set_mask;
    tag_in   = TAG_W'(shifted >> sb_eff);
  end

  // set memory; rows not yet written read as empty with identity order
  row_t                mem [NUM_SETS];
  logic [NUM_SETS-1:0] row_init_r;
  row_t                rd_row_r;
  logic                rd_init_r;
  set_t                set_r;
  tag_t                tag_r;
  row_t                wr_row;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_row_r <= mem[set_in];
      set_r    <= set_in;
      tag_r    <= tag_in;
    end
    if (cmd.upd_en) begin
      mem[set_r] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
      rd_init_r  <= 1'b0;
    end else begin
      if (cmd.rd_en) rd_init_r <= row_init_r[set_in];
      if (cmd.upd_en) row_init_r[set_r] <= 1'b1;
    end
  end

  // lookup and replacement
  way_t [WAYS-1:0] order;
  way_t [WAYS-1:0] order_nxt;
  logic [WAYS-1:0] vld;
  logic            hit;
  way_t            hit_way;
  logic            have_empty;
  way_t            empty_way;
  way_t            sel_way;
  logic [OUTC_W-1:0] outcome;
  logic            pos_found;
  way_t            pos;

  always_comb begin
    vld        = rd_init_r ? rd_row_r.valid : '0;
    order      = rd_init_r ? rd_row_r.lru : lru_identity();
    hit        = 1'b0;
    hit_way    = '0;
    have_empty = 1'b0;
    empty_way  = '0;
    // descending so the lowest matching way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vld[w] && (rd_row_r.tag[w] == tag_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    // ascending so the highest empty way wins
    for (int w = 0; w < WAYS; w++) begin
      if (!vld[w]) begin
        have_empty = 1'b1;
        empty_way  = WAY_W'(w);
      end
    end
    priority if (hit) begin
      sel_way = hit_way;
      outcome = OUTC_HIT;
    end else if (have_empty) begin
      sel_way = empty_way;
      outcome = OUTC_FILL;
    end else begin
      sel_way = order[0];
      outcome = OUTC_EVICT;
    end

    // move sel_way to the MRU end
    pos_found = 1'b0;
    pos       = '0;
    for (int p = WAYS - 1; p >= 0; p--) begin
      if (order[p] == sel_way) begin
        pos_found = 1'b1;
        pos       = WAY_W'(p);
      end
    end
    order_nxt = order;
    if (pos_found) begin
      for (int q = 0; q < WAYS - 1; q++) begin
        if (WAY_W'(q) >= pos) order_nxt[q] = order[q + 1];
      end
      order_nxt[WAYS-1] = sel_way;
    end

    wr_row       = rd_row_r;
    wr_row.lru   = order_nxt;
    wr_row.valid = vld;
    if (!hit) begin
      wr_row.valid[sel_way] = 1'b1;
      wr_row.tag[sel_way]   = tag_r;
    end
  end

  // counters and result registers
  cnt_t hit_cnt_r, miss_cnt_r, evict_cnt_r;
  cnt_t hit_cnt_nxt, miss_cnt_nxt, evict_cnt_nxt;
  logic [OUTC_W-1:0] outcome_r;
  logic [OWAY_W-1:0] way_r;

  always_comb begin
    hit_cnt_nxt   = hit ? sat_inc(hit_cnt_r) : hit_cnt_r;
    miss_cnt_nxt  = hit ? miss_cnt_r : sat_inc(miss_cnt_r);
    evict_cnt_nxt = (outcome == OUTC_EVICT) ? sat_inc(evict_cnt_r) : evict_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (cmd.upd_en) begin
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en) begin
      outcome_r <= outcome;
      way_r     <= OWAY_W'(sel_way);
    end
  end

  assign out_outcome        = outcome_r;
  assign out_way            = way_r;
  assign out_hit_count      = hit_cnt_r;
  assign out_miss_count     = miss_cnt_r;
  assign out_eviction_count = evict_cnt_r;

endmodule

[hw/rtl/set_assoc_cache_lru_unit.sv]
// Top level of the tag-only set-associative cache model with true LRU.
//
// Input: raise start with in_address; the item is taken at an edge where
// busy is low. The address loses offset_bits low bits, the next set_bits
// bits pick one of up to 256 sets and the rest is the tag.
// Result: out_valid goes high at the edge after the item was taken and
// stays high for one cycle; the result, valid while out_valid is high,
// is out_outcome (hit, fill of an empty way, or eviction),
// out_way and the three saturating counters. The receiver cannot stall.
// The set memory holds tags, valid bits and LRU order of one set per row;
// each item reads its row at the accepting edge and writes it back at the
// next, with busy high between; no item is taken before the write-back.
// Configuration: cfg_we with cfg_index 0 (offset_bits) or 1 (set_bits)
// writes cfg_data at once; write only while no item is in flight.
// Reset (synchronous, rst_n low): counters clear, registers go to 4 and
// 4, and every set reads as empty with way order 0..3 until first written.
// No clearing pass is needed; the block accepts items right after reset.
module set_assoc_cache_lru_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [sacl_pkg::ADDR_BITS-1:0]    in_address,
  input  logic                              cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sacl_pkg::CFG_W-1:0]        cfg_data,
  output logic                              out_valid,
  output logic [sacl_pkg::OUTC_W-1:0]       out_outcome,
  output logic [sacl_pkg::OWAY_W-1:0]       out_way,
  output logic [sacl_pkg::CNT_W-1:0]        out_hit_count,
  output logic [sacl_pkg::CNT_W-1:0]        out_miss_count,
  output logic [sacl_pkg::CNT_W-1:0]        out_eviction_count
);
  import sacl_pkg::*;

  dp_cmd_t cmd;

  sacl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  sacl_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_address         (in_address),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_outcome        (out_outcome),
    .out_way            (out_way),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count),
    .out_eviction_count (out_eviction_count)
  );

endmodule
